// ===== hdl/spl_pkg.sv =====
// shared types and codes for the sorted priority list
package spl_pkg;

	localparam int HandleW = 8;
	localparam int PrioW   = 8;

	// request selector codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LIST   = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_ENTRY    = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [PrioW-1:0]   prio;
		logic [HandleW-1:0] handle;
	} entry_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   rot;
		entry_t ent;
	} cell_ctrl_t;

	typedef enum logic {
		IDLE,
		LIST
	} state_t;

endpackage

// ===== hdl/spl_cell.sv =====
// one compare-and-shift cell of the sorted list chain
module spl_cell (
	input  logic               clk,
	input  spl_pkg::cell_ctrl_t ctrl,
	input  logic               valid,
	input  logic               tail,
	input  logic               prev_gt,
	input  spl_pkg::entry_t    prev_ent,
	input  spl_pkg::entry_t    next_ent,
	input  spl_pkg::entry_t    head_ent,
	output spl_pkg::entry_t    ent,
	output logic               gt
);

	spl_pkg::entry_t ent_q;
	spl_pkg::entry_t ent_d;

	// stored entry outranks the new one, so it stays in place
	assign gt = valid && (ent_q.prio > ctrl.ent.prio);

	// insert: keep, take new, or take the left neighbor; rotate: shift toward head
	always_comb begin
		ent_d = ent_q;
		if (ctrl.ins) begin
			if (gt) begin
				ent_d = ent_q;
			end else if (prev_gt) begin
				ent_d = ctrl.ent;
			end else begin
				ent_d = prev_ent;
			end
		end else if (ctrl.rot) begin
			ent_d = tail ? head_ent : next_ent;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign ent = ent_q;

endmodule

// ===== hdl/sorted_priority_list_top.sv =====
// sorted priority list: chain of compare-and-shift cells with a stream front end
// a result is in the output register in the cycle after its request transfer
// insert: all cells compare and shift in parallel; a further request is taken while the output can load
// read-out of n entries: n results, one per unstalled cycle, chain rotates toward head
// a new request is taken once the last result of the previous one is loaded
// reset clears the entry count and handshake state; stored entries are not reset
module sorted_priority_list_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // handle [7:0], prio [15:8]
	input  logic        s_tuser,  // req_type [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_handle [7:0], out_prio [15:8]
	output logic [1:0]  m_tuser,  // status [1:0]
	output logic        m_tlast
);

	localparam int CW = $clog2(DEPTH + 1);

	spl_pkg::state_t     state_q;
	spl_pkg::state_t     state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rem_q;
	spl_pkg::cell_ctrl_t ctrl;
	spl_pkg::entry_t     cell_ent [DEPTH];
	logic [DEPTH-1:0]    cell_gt;
	spl_pkg::entry_t     in_ent;
	spl_pkg::entry_t     head;
	logic                acc;
	logic                can_load;
	logic                full;
	logic                out_ld;
	logic [1:0]          out_status;
	spl_pkg::entry_t     out_ent;
	logic                out_last;
	logic                m_tvalid_q;
	logic [1:0]          status_q;
	spl_pkg::entry_t     out_ent_q;
	logic                last_q;

	assign in_ent   = spl_pkg::entry_t'(s_tdata);
	assign head     = cell_ent[0];
	assign can_load = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign full     = (count_q == CW'(DEPTH));

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spl_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.valid    (CW'(i) < count_q),
			.tail     (count_q == CW'(i + 1)),
			.prev_gt  ((i == 0) ? 1'b1 : cell_gt[(i == 0) ? 0 : i - 1]),
			.prev_ent (cell_ent[(i == 0) ? 0 : i - 1]),
			.next_ent (cell_ent[(i == DEPTH - 1) ? 0 : i + 1]),
			.head_ent (head),
			.ent      (cell_ent[i]),
			.gt       (cell_gt[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spl_pkg::IDLE: begin
				if (acc && s_tuser == spl_pkg::REQ_LIST && count_q > CW'(1)) begin
					state_d = spl_pkg::LIST;
				end
			end
			spl_pkg::LIST: begin
				if (can_load && rem_q == CW'(1)) begin
					state_d = spl_pkg::IDLE;
				end
			end
			default: state_d = spl_pkg::IDLE;
		endcase
	end

	// handshake, cell commands and the next result
	always_comb begin
		s_tready   = 1'b0;
		out_ld     = 1'b0;
		ctrl.ins   = 1'b0;
		ctrl.rot   = 1'b0;
		ctrl.ent   = in_ent;
		out_status = spl_pkg::ST_INSERTED;
		out_ent    = '0;
		out_last   = 1'b1;
		case (state_q)
			spl_pkg::IDLE: begin
				s_tready = can_load;
				out_ld   = acc;
				if (s_tuser == spl_pkg::REQ_INSERT) begin
					ctrl.ins   = acc && !full;
					out_status = full ? spl_pkg::ST_FULL : spl_pkg::ST_INSERTED;
				end else if (count_q == '0) begin
					out_status = spl_pkg::ST_EMPTY;
				end else begin
					ctrl.rot   = acc;
					out_status = spl_pkg::ST_ENTRY;
					out_ent    = head;
					out_last   = (count_q == CW'(1));
				end
			end
			spl_pkg::LIST: begin
				out_ld     = can_load;
				ctrl.rot   = can_load;
				out_status = spl_pkg::ST_ENTRY;
				out_ent    = head;
				out_last   = (rem_q == CW'(1));
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= spl_pkg::IDLE;
			count_q    <= '0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == spl_pkg::IDLE && ctrl.rot) begin
				rem_q <= count_q - CW'(1);
			end else if (state_q == spl_pkg::LIST && can_load) begin
				rem_q <= rem_q - CW'(1);
			end
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (out_ld) begin
			status_q  <= out_status;
			out_ent_q <= out_ent;
			last_q    <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 16'(out_ent_q);
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == spl_pkg::REQ_INSERT && full
		|=> $stable(count_q) && m_tuser == spl_pkg::ST_FULL)
		else $error("insert on full list changed the list");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == spl_pkg::REQ_INSERT && !full
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_list_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spl_pkg::LIST |-> !s_tready && rem_q != '0)
		else $error("request taken during read-out");
`endif

endmodule
